FILE: hw/rtl/cdsd_pkg.sv
// ----------------------------------------------------------------------------
// cdsd_pkg: shared types and constants for the contour diameter unit
// Transaction payload structs, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package cdsd_pkg;

  // Fixed field widths of the input and result transactions.
  localparam int COORD_FIELD_W = 12;
  localparam int SQ_W          = 25;
  localparam int FIX_W         = 21;
  localparam int FRAC_BITS     = 8;

  typedef struct packed {
    logic [COORD_FIELD_W-1:0] point_x;
    logic [COORD_FIELD_W-1:0] point_y;
    logic                     last_point;
  } point_item_t;

  typedef struct packed {
    logic [SQ_W-1:0]  diameter_squared;
    logic [FIX_W-1:0] diameter_fixed;
    logic             overflowed;
  } result_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START_RD,
    ST_START_LATCH,
    ST_SWEEP,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cdsd_isqrt.sv
// ----------------------------------------------------------------------------
// cdsd_isqrt: digit-serial integer square root
// Returns floor(sqrt(radicand * 2^(2*FRAC_BITS))), one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdsd_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [cdsd_pkg::SQ_W-1:0] radicand,
  output logic                           done,
  output logic [cdsd_pkg::FIX_W-1:0]     root
);

  localparam int FW   = cdsd_pkg::FIX_W;
  localparam int VW   = 2 * FW;
  localparam int REMW = FW + 3;
  localparam int STW  = $clog2(FW + 1);

  logic [VW-1:0]   val;
  logic [REMW-1:0] rem;
  logic [STW-1:0]  steps;
  logic            running;

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            fits;

  always_comb begin
    rem_sh = {rem[REMW-3:0], val[VW-1 -: 2]};
    trial  = REMW'({root, 2'b01});
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STW'(FW);
      end else if (running) begin
        steps <= steps - STW'(1);
        if (steps == STW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= VW'(radicand) << (2 * cdsd_pkg::FRAC_BITS);
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      val  <= val << 2;
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[FW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/contour_double_sweep_diameter_unit.sv
// ----------------------------------------------------------------------------
// contour_double_sweep_diameter_unit: double-sweep contour diameter
// Stores contour points, runs two farthest-point sweeps and reports the
// squared diameter, its 13.8 fixed-point square root and an overflow flag.
// ----------------------------------------------------------------------------
// Usage: a point transaction is taken at a rising edge where start is high
// and busy is low. While a contour loads, busy stays low and one point can
// be taken every cycle; each point is written into the point memory. The
// point that carries last_point raises busy and starts the computation.
// The states ST_START_RD and ST_START_LATCH fetch the first stored point.
// The first sweep then reads every stored point from the memory and keeps
// the point farthest from the first stored point (earliest one on ties).
// The second sweep does the same from that point. The memory read, the
// coordinate differences, the squares and the compare form a four-stage
// pipeline. The square root then works out one root bit per cycle, and the
// result is shown on result for exactly one cycle with done high. Busy
// stays high until the result has been shown, so no point of the next
// contour is taken while one is computed. The receiver cannot stall: the
// result is gone after its strobe cycle. Points beyond MAX_POINTS are
// dropped and flagged. Synchronous reset empties the contour; the memory
// itself is not cleared, since only entries below the point count are
// ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module contour_double_sweep_diameter_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire cdsd_pkg::point_item_t  point,
  output logic                        done,
  output cdsd_pkg::result_item_t      result
);

  // Coordinates are kept to COORD_BITS bits, and never exceed the field.
  localparam int CW   = (COORD_BITS < cdsd_pkg::COORD_FIELD_W) ?
                        COORD_BITS : cdsd_pkg::COORD_FIELD_W;
  localparam int PW   = 2 * CW;
  localparam int DW   = 2 * CW + 1;
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  cdsd_pkg::state_t state, state_next;

  // Point memory: one write port for loading, one registered read port.
  logic [PW-1:0] point_mem [MAX_POINTS];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] rd_data;

  logic [CNTW-1:0] point_count;
  logic            overflow_flag;
  logic            store_full;
  logic            accept;
  logic [AW-1:0]   last_idx;

  logic [AW-1:0] rd_idx;
  logic          second_pass;
  logic          drained;

  // Sweep pipeline registers.
  logic          a_valid, b_valid, c_valid;
  logic [CW-1:0] dx, dy;
  logic [PW-1:0] b_pt, c_pt;
  logic [PW-1:0] sq_x, sq_y;
  logic [DW-1:0] pair_dist;

  logic [PW-1:0] sweep_start;
  logic [PW-1:0] sweep_best;
  logic [DW-1:0] best_distance;

  logic [CW-1:0] cur_x, cur_y, ref_x, ref_y;

  logic                           root_start;
  logic                           root_done;
  logic [cdsd_pkg::FIX_W-1:0]     root;

  assign store_full = (point_count == CNTW'(MAX_POINTS));
  assign last_idx   = AW'(point_count - CNTW'(1));
  assign drained    = !a_valid && !b_valid && !c_valid;
  assign wr_addr    = point_count[AW-1:0];
  assign wr_data    = {point.point_y[CW-1:0], point.point_x[CW-1:0]};

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      cdsd_pkg::ST_LOAD: begin
        if (accept && point.last_point) state_next = cdsd_pkg::ST_START_RD;
      end
      cdsd_pkg::ST_START_RD:    state_next = cdsd_pkg::ST_START_LATCH;
      cdsd_pkg::ST_START_LATCH: state_next = cdsd_pkg::ST_SWEEP;
      cdsd_pkg::ST_SWEEP: begin
        if (rd_idx == last_idx) state_next = cdsd_pkg::ST_DRAIN;
      end
      cdsd_pkg::ST_DRAIN: begin
        if (drained) begin
          state_next = second_pass ? cdsd_pkg::ST_ROOT : cdsd_pkg::ST_SWEEP;
        end
      end
      cdsd_pkg::ST_ROOT: begin
        if (root_done) state_next = cdsd_pkg::ST_EMIT;
      end
      cdsd_pkg::ST_EMIT:        state_next = cdsd_pkg::ST_LOAD;
      default:                  state_next = cdsd_pkg::ST_LOAD;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    busy       = (state != cdsd_pkg::ST_LOAD);
    accept     = start && !busy;
    wr_en      = accept && !store_full;
    rd_en      = (state == cdsd_pkg::ST_START_RD) || (state == cdsd_pkg::ST_SWEEP);
    rd_addr    = (state == cdsd_pkg::ST_SWEEP) ? rd_idx : '0;
    root_start = (state == cdsd_pkg::ST_DRAIN) && drained && second_pass;
    done       = (state == cdsd_pkg::ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdsd_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      point_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= point_mem[rd_addr];
    end
  end

  // Contour bookkeeping: fill count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      overflow_flag <= 1'b0;
    end else if (state == cdsd_pkg::ST_EMIT) begin
      point_count   <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      if (store_full) begin
        overflow_flag <= 1'b1;
      end else begin
        point_count <= point_count + CNTW'(1);
      end
    end
  end

  // Sweep control: read index, pass flag and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_pass <= 1'b0;
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
    end else begin
      a_valid <= (state == cdsd_pkg::ST_SWEEP);
      b_valid <= a_valid;
      c_valid <= b_valid;
      if (state == cdsd_pkg::ST_START_LATCH) begin
        second_pass <= 1'b0;
      end else if (state == cdsd_pkg::ST_DRAIN && drained) begin
        second_pass <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cdsd_pkg::ST_SWEEP) begin
      rd_idx <= rd_idx + AW'(1);
    end else begin
      rd_idx <= '0;
    end
  end

  always_comb begin
    cur_x     = rd_data[CW-1:0];
    cur_y     = rd_data[PW-1:CW];
    ref_x     = sweep_start[CW-1:0];
    ref_y     = sweep_start[PW-1:CW];
    pair_dist = DW'(sq_x) + DW'(sq_y);
  end

  // Sweep datapath: differences, squares, then compare against the best.
  always_ff @(posedge clk) begin
    dx   <= (cur_x > ref_x) ? (cur_x - ref_x) : (ref_x - cur_x);
    dy   <= (cur_y > ref_y) ? (cur_y - ref_y) : (ref_y - cur_y);
    b_pt <= rd_data;
    sq_x <= PW'(dx) * PW'(dx);
    sq_y <= PW'(dy) * PW'(dy);
    c_pt <= b_pt;

    if (state == cdsd_pkg::ST_START_LATCH) begin
      // The first sweep measures from the first stored point.
      sweep_start   <= rd_data;
      sweep_best    <= rd_data;
      best_distance <= '0;
    end else if (state == cdsd_pkg::ST_DRAIN && drained && !second_pass) begin
      // The second sweep measures from the point the first one found.
      sweep_start   <= sweep_best;
      best_distance <= '0;
    end else if (c_valid && (pair_dist > best_distance)) begin
      // Strict compare keeps the earliest point among equal distances.
      best_distance <= pair_dist;
      sweep_best    <= c_pt;
    end
  end

  cdsd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (cdsd_pkg::SQ_W'(best_distance)),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    result.diameter_squared = cdsd_pkg::SQ_W'(best_distance);
    result.diameter_fixed   = root;
    result.overflowed       = overflow_flag;
  end

endmodule

`default_nettype wire
